### sv/dccser_pkg.sv
`default_nettype none
package dccser_pkg;

  // Default length of the run of ones that opens every packet.
  localparam int PREAMBLE_BITS_DEFAULT = 14;

  // Bits after the preamble: start, address, separator, command, separator,
  // checksum and the closing bit.
  localparam int FRAME_TAIL_BITS = 28;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Fixed parts of a speed command byte.
  localparam logic [1:0] CMD_SPEED_HEADER = 2'b01;

  typedef struct packed {
    logic [7:0] loco_address;
    logic [4:0] speed_step;
    logic       direction_forward;
  } command_t;

  typedef struct packed {
    logic packet_bit;
    logic last_bit;
  } packet_t;

  // One packet ready for transmission.
  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
  } frame_t;

  // Handshake between two internal stages.
  typedef struct packed {
    logic valid;
    logic stall;
  } link_t;

endpackage
`default_nettype wire

### sv/dccser_front.sv
`default_nettype none
module dccser_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               command_valid,
  output logic                    command_stall,
  input  wire dccser_pkg::command_t command,
  output logic                    push_valid,
  input  wire logic               push_stall,
  output dccser_pkg::frame_t      push_frame
);
  import dccser_pkg::*;

  logic [7:0] last_command_byte;
  logic [7:0] built_command;
  logic       accept;

  // New command byte: header, direction, speed with bit 0 ORed into bit 4.
  always_comb begin
    built_command = {CMD_SPEED_HEADER, command.direction_forward,
                     command.speed_step[4] | command.speed_step[0],
                     command.speed_step[3:0]};
  end

  assign accept        = command_valid && !push_stall;
  assign command_stall = push_stall;
  assign push_valid    = command_valid;

  always_comb begin
    push_frame.address = command.loco_address;
    if (command.speed_step != 5'd0) begin
      push_frame.command = built_command;
    end else begin
      push_frame.command = last_command_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_command_byte <= 8'd0;
    end else if (accept && command.speed_step != 5'd0) begin
      last_command_byte <= built_command;
    end
  end

endmodule
`default_nettype wire

### sv/dccser_queue.sv
`default_nettype none
module dccser_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_stall,
  input  wire dccser_pkg::frame_t push_frame,
  output dccser_pkg::link_t       pop_link_out,
  input  wire logic               pop_stall,
  output dccser_pkg::frame_t      pop_frame
);
  import dccser_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  frame_t           entries [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_stall         = (count == FULL_COUNT);
  assign pop_link_out.valid = (count != '0);
  assign pop_link_out.stall = pop_stall;
  assign push               = push_valid && !push_stall;
  assign pop                = pop_link_out.valid && !pop_stall;
  assign pop_frame          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue fill count beyond its depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == CNT_W'(1)) |=> !pop_link_out.valid)
    else $error("queue still shows an entry after the last one left");

endmodule
`default_nettype wire

### sv/dccser_back.sv
`default_nettype none
module dccser_back #(
  parameter int PREAMBLE_BITS = dccser_pkg::PREAMBLE_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dccser_pkg::link_t  pop_link,
  output logic                    pop_stall,
  input  wire dccser_pkg::frame_t pop_frame,
  output logic                    packet_valid,
  input  wire logic               packet_stall,
  output dccser_pkg::packet_t     packet
);
  import dccser_pkg::*;

  localparam int TOTAL = PREAMBLE_BITS + FRAME_TAIL_BITS;
  localparam int CNT_W = $clog2(TOTAL);
  localparam logic [CNT_W-1:0] START_POS  = CNT_W'(PREAMBLE_BITS);
  localparam logic [CNT_W-1:0] ADDR_START = CNT_W'(PREAMBLE_BITS + 1);
  localparam logic [CNT_W-1:0] SEP1_POS   = CNT_W'(PREAMBLE_BITS + 9);
  localparam logic [CNT_W-1:0] CMD_START  = CNT_W'(PREAMBLE_BITS + 10);
  localparam logic [CNT_W-1:0] SEP2_POS   = CNT_W'(PREAMBLE_BITS + 18);
  localparam logic [CNT_W-1:0] CHK_START  = CNT_W'(PREAMBLE_BITS + 19);
  localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(TOTAL - 1);

  logic             busy;
  logic [CNT_W-1:0] pos;
  frame_t           frame;
  logic [7:0]       checksum;
  logic [CNT_W-1:0] rel;
  logic             take;
  logic             take_last;
  logic             load;

  assign checksum  = frame.address ^ frame.command;
  assign take      = busy && !packet_stall;
  assign take_last = take && (pos == LAST_POS);
  assign pop_stall = busy && !take_last;
  assign load      = pop_link.valid && !pop_link.stall;

  assign packet_valid = busy;

  // Select the bit for the current position, bytes most significant first.
  always_comb begin
    rel               = '0;
    packet.last_bit   = 1'b0;
    packet.packet_bit = 1'b0;
    if (pos < START_POS) begin
      packet.packet_bit = 1'b1;
    end else if (pos == START_POS || pos == SEP1_POS || pos == SEP2_POS) begin
      packet.packet_bit = 1'b0;
    end else if (pos < SEP1_POS) begin
      rel               = pos - ADDR_START;
      packet.packet_bit = frame.address[3'd7 - rel[2:0]];
    end else if (pos < SEP2_POS) begin
      rel               = pos - CMD_START;
      packet.packet_bit = frame.command[3'd7 - rel[2:0]];
    end else if (pos < LAST_POS) begin
      rel               = pos - CHK_START;
      packet.packet_bit = checksum[3'd7 - rel[2:0]];
    end else begin
      packet.packet_bit = 1'b1;
      packet.last_bit   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= pop_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (take_last) begin
      busy <= 1'b0;
    end else if (take) begin
      pos <= pos + 1'b1;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= LAST_POS)
    else $error("bit position beyond the end of the packet");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (take_last && !pop_link.valid) |=> !busy)
    else $error("serializer stays busy with nothing queued");

  a_next_packet_starts: assert property (@(posedge clk) disable iff (rst)
    (take_last && pop_link.valid) |=> (busy && pos == '0))
    else $error("queued packet does not follow the closing bit");

endmodule
`default_nettype wire

### sv/dccser_speed_top.sv
`default_nettype none
// Baseline speed packet serializer.
//
// The command channel (command_valid, command_stall, command) takes one
// locomotive command: address, speed step and direction. A nonzero speed
// builds a fresh command byte; a zero speed resends the byte kept from the
// last packet, which is zero after reset. Each item yields one packet on the
// packet channel (packet_valid, packet_stall, packet), one bit per item in
// transmission order: the preamble of ones, a start bit, address, separator,
// command, separator, checksum and a closing one flagged by last_bit.
//
// A packet is PREAMBLE_BITS + 28 items long, 42 at the default preamble, and
// the serializer emits one bit per cycle while the receiver does not stall.
// The first bit is offered once the command has been written into the queue
// and then loaded into the serializer. A two-entry queue sits between the
// command front and the serializer, so further commands are taken while a
// packet is still going out, and the next packet follows the closing bit
// with no gap. A stall from the receiver holds the current bit; once the
// queue is full, command_stall rises. Synchronous reset empties the queue,
// drops any packet in flight and clears the kept byte.
module dcc_speed_packet_serializer_top #(
  parameter int PREAMBLE_BITS = dccser_pkg::PREAMBLE_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 command_valid,
  output logic                      command_stall,
  input  wire dccser_pkg::command_t command,
  output logic                      packet_valid,
  input  wire logic                 packet_stall,
  output dccser_pkg::packet_t       packet
);
  import dccser_pkg::*;

  // Front to queue.
  logic   push_valid;
  logic   push_stall;
  frame_t push_frame;

  // Queue to serializer.
  link_t  pop_link;
  logic   pop_stall;
  frame_t pop_frame;

  // The front settles the command byte and keeps the last one.
  dccser_front u_front (
    .clk           (clk),
    .rst           (rst),
    .command_valid (command_valid),
    .command_stall (command_stall),
    .command       (command),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_frame    (push_frame)
  );

  // Packets waiting for the serializer.
  dccser_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_frame   (push_frame),
    .pop_link_out (pop_link),
    .pop_stall    (pop_stall),
    .pop_frame    (pop_frame)
  );

  // The serializer walks a bit counter across the packet.
  dccser_back #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_link     (pop_link),
    .pop_stall    (pop_stall),
    .pop_frame    (pop_frame),
    .packet_valid (packet_valid),
    .packet_stall (packet_stall),
    .packet       (packet)
  );

endmodule
`default_nettype wire
